// ===== rtl/mpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants of the product-scanning multiplier core.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int FIELD_W = 64;   // limb field width on the ports
    localparam int POS_W   = 5;    // limb_position width

    // Register index decoded from the config address
    localparam logic [0:0] REG_LIMB_COUNT = 1'b0;

    typedef struct packed {
        logic [FIELD_W-1:0] u_limb;
        logic [FIELD_W-1:0] v_limb;
    } t_operands;

    typedef struct packed {
        logic [FIELD_W-1:0] product_limb;
        logic [POS_W-1:0]   limb_position;
        logic               last_limb;
    } t_result;

    // Tag that travels with each slot down the multiply pipe
    typedef struct packed {
        logic             prod;   // slot carries a limb product
        logic             emit;   // column ends here: emit low limb, shift
        logic             last;   // most significant product limb
        logic [POS_W-1:0] pos;
    } t_slot;

    typedef struct packed {
        logic  wr_en;   // write operand pair to the stores
        logic  issue;   // launch a slot into the pipe
        t_slot slot;
    } t_ctl_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

endpackage

// ===== rtl/mpsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpsm_ctrl
// Load counter and column/row scan sequencer of the multiplier.
// ----------------------------------------------------------------------------
module mpsm_ctrl #(
    parameter int MAX_LIMBS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_cfg_wr,
    input  logic [4:0]            i_limb_count,
    input  mpsm_pkg::t_dp_status  i_status,
    output logic                  o_busy,
    output mpsm_pkg::t_ctl_cmd    o_cmd,
    output logic [IDX_W-1:0]      o_wr_idx,
    output logic [IDX_W-1:0]      o_rd_i,
    output logic [IDX_W-1:0]      o_rd_j
);
    import mpsm_pkg::*;

    localparam int CNT_W = $clog2(MAX_LIMBS + 1);
    localparam int COL_W = (MAX_LIMBS > 1) ? $clog2(2 * MAX_LIMBS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL,
        S_DRAIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_load, n_load;
    logic [COL_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;

    logic [CNT_W-1:0] w_n;
    logic [IDX_W-1:0] w_nm1;
    logic [CNT_W:0]   w_load_inc;
    logic [COL_W:0]   w_c1;
    logic [COL_W:0]   w_col_max;
    logic             w_col_end;
    logic             w_col_last;

    // effective limb count: zero reads as one, large values saturate
    always_comb begin
        if (i_limb_count == 5'd0) begin
            w_n = CNT_W'(1);
        end else if (int'(i_limb_count) > MAX_LIMBS) begin
            w_n = CNT_W'(MAX_LIMBS);
        end else begin
            w_n = CNT_W'(i_limb_count);
        end
    end

    assign w_nm1      = IDX_W'(w_n - 1'b1);
    assign w_load_inc = {1'b0, r_load} + 1'b1;
    assign w_c1       = {1'b0, r_col} + 1'b1;
    assign w_col_max  = (COL_W + 1)'(2 * int'(w_n) - 2);
    assign w_col_end  = (r_i == w_nm1) || (r_j == '0);
    assign w_col_last = ({1'b0, r_col} == w_col_max);

    assign o_wr_idx = r_load[IDX_W-1:0];
    assign o_rd_i   = r_i;
    assign o_rd_j   = r_j;
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_load  = r_load;
        n_col   = r_col;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.wr_en = 1'b1;
                    if (w_load_inc == {1'b0, w_n}) begin
                        n_state = S_SCAN;
                        n_load  = '0;
                        n_col   = '0;
                        n_i     = '0;
                        n_j     = '0;
                    end else begin
                        n_load = w_load_inc[CNT_W-1:0];
                    end
                end
                if (i_cfg_wr) begin
                    n_load = '0;
                end
            end
            S_SCAN: begin
                o_cmd.issue     = 1'b1;
                o_cmd.slot.prod = 1'b1;
                o_cmd.slot.emit = w_col_end;
                o_cmd.slot.pos  = POS_W'(r_col);
                if (w_col_end) begin
                    if (w_col_last) begin
                        n_state = S_FINAL;
                    end else begin
                        n_col = w_c1[COL_W-1:0];
                        if (w_c1 < (COL_W + 1)'(w_n)) begin
                            n_i = '0;
                            n_j = IDX_W'(w_c1);
                        end else begin
                            n_i = IDX_W'(w_c1 - (COL_W + 1)'(w_n) + 1'b1);
                            n_j = w_nm1;
                        end
                    end
                end else begin
                    n_i = r_i + 1'b1;
                    n_j = r_j - 1'b1;
                end
            end
            S_FINAL: begin
                // top column has no products, only the leftover accumulator
                o_cmd.issue     = 1'b1;
                o_cmd.slot.emit = 1'b1;
                o_cmd.slot.last = 1'b1;
                o_cmd.slot.pos  = POS_W'(w_c1);
                n_state         = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_load  <= '0;
            r_col   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_load  <= n_load;
            r_col   <= n_col;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

endmodule

// ===== rtl/mpsm_datapath.sv =====
// ----------------------------------------------------------------------------
// mpsm_datapath
// Operand stores, pipelined limb multiplier and three-limb column accumulator.
// ----------------------------------------------------------------------------
module mpsm_datapath #(
    parameter int MAX_LIMBS = 16,
    parameter int LIMB_BITS = 64,
    parameter int IDX_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mpsm_pkg::t_ctl_cmd    i_cmd,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  logic [IDX_W-1:0]      i_rd_i,
    input  logic [IDX_W-1:0]      i_rd_j,
    input  mpsm_pkg::t_operands   i_operands,
    output mpsm_pkg::t_dp_status  o_status,
    output logic                  o_result_valid,
    output mpsm_pkg::t_result     o_result
);
    import mpsm_pkg::*;

    localparam int ACC_W = 3 * LIMB_BITS;

    logic [LIMB_BITS-1:0] mem_u [MAX_LIMBS];
    logic [LIMB_BITS-1:0] mem_v [MAX_LIMBS];

    // stage a: store read
    logic                 r_a_v;
    t_slot                r_a_slot;
    logic [LIMB_BITS-1:0] r_u, r_v;
    // stage b: 32x32 partial products
    logic                 r_b_v;
    t_slot                r_b_slot;
    logic [63:0]          r_p00, r_p01, r_p10, r_p11;
    // stage c: full double-limb product
    logic                 r_c_v;
    t_slot                r_c_slot;
    logic [127:0]         r_prod;
    // accumulator and result
    logic [ACC_W-1:0]     r_acc;
    logic                 r_res_v;
    t_result              r_res;

    logic [63:0]          w_ua, w_ub;
    logic [127:0]         w_prod;
    logic [ACC_W-1:0]     w_sum;

    assign w_ua   = 64'(r_u);
    assign w_ub   = 64'(r_v);
    assign w_prod = {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                  + {r_p11, 64'd0};
    assign w_sum  = r_acc + ACC_W'(r_prod);

    assign o_status.pipe_busy = r_a_v | r_b_v | r_c_v;
    assign o_result_valid     = r_res_v;
    assign o_result           = r_res;

    // operand stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_u[i_wr_idx] <= i_operands.u_limb[LIMB_BITS-1:0];
            mem_v[i_wr_idx] <= i_operands.v_limb[LIMB_BITS-1:0];
        end
        if (i_cmd.issue) begin
            r_u <= mem_u[i_rd_i];
            r_v <= mem_v[i_rd_j];
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_a_slot <= i_cmd.slot;
        r_b_slot <= r_a_slot;
        r_c_slot <= r_b_slot;
        r_p00    <= w_ua[31:0]  * w_ub[31:0];
        r_p01    <= w_ua[31:0]  * w_ub[63:32];
        r_p10    <= w_ua[63:32] * w_ub[31:0];
        r_p11    <= w_ua[63:32] * w_ub[63:32];
        r_prod   <= r_b_slot.prod ? w_prod : '0;
        if (r_c_v && r_c_slot.emit) begin
            r_res.product_limb  <= 64'(w_sum[LIMB_BITS-1:0]);
            r_res.limb_position <= r_c_slot.pos;
            r_res.last_limb     <= r_c_slot.last;
        end
    end

    // valids and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_res_v <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_a_v   <= i_cmd.issue;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            r_res_v <= r_c_v && r_c_slot.emit;
            if (r_c_v) begin
                if (r_c_slot.emit && r_c_slot.last) begin
                    r_acc <= '0;
                end else if (r_c_slot.emit) begin
                    r_acc <= w_sum >> LIMB_BITS;
                end else begin
                    r_acc <= w_sum;
                end
            end
        end
    end

endmodule

// ===== rtl/multiword_product_scanning_multiplier_core.sv =====
// ----------------------------------------------------------------------------
// multiword_product_scanning_multiplier_core
// Multiprecision unsigned multiplier, product scanning (column by column).
// ----------------------------------------------------------------------------
// Usage:
//   Input beats: drive i_operands with one limb pair (least significant first)
//   and raise start; the beat is taken on an edge with start high, busy low.
//   The beat that completes n pairs (n from limb_count, zero read as one,
//   saturated at MAX_LIMBS) starts the product: busy rises and 2n result
//   beats follow, each a one-cycle o_result_valid strobe with limb_position
//   and last_limb on the top limb.
//   Pipeline: the scan issues one limb product per cycle through a four-stage
//   pipe (store read, 32x32 partial products, product sum, accumulate) on
//   the single 64x64 multiplier slice, built from four 32x32 multipliers.
//   No new pair is taken while a product is in flight (busy high).
//   Results cannot be stalled; the receiver must take each strobe.
//   Config: APB, limb_count at byte address 0. Writing it drops the pairs
//   loaded so far. Write only while busy is low.
//   Reset: limb_count = 1, no pairs loaded, accumulator clear. Store contents
//   are not reset; only entries loaded for the current product are read.
// ----------------------------------------------------------------------------
module multiword_product_scanning_multiplier_core #(
    parameter int MAX_LIMBS = 16,
    parameter int LIMB_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  mpsm_pkg::t_operands  i_operands,
    // result channel
    output logic                 o_result_valid,
    output mpsm_pkg::t_result    o_result,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import mpsm_pkg::*;

    localparam int IDX_W = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;

    logic [4:0]       r_limb_count;
    logic             w_cfg_wr;
    logic             w_start;
    t_ctl_cmd         w_cmd;
    t_dp_status       w_status;
    logic [IDX_W-1:0] w_wr_idx, w_rd_i, w_rd_j;

    // config register: word index is paddr[2], only index 0 exists
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LIMB_COUNT);
    assign prdata   = (paddr[2] == REG_LIMB_COUNT) ? {27'd0, r_limb_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limb_count <= 5'd1;
        end else if (w_cfg_wr) begin
            r_limb_count <= pwdata[4:0];
        end
    end

    assign w_start = start && !busy;

    mpsm_ctrl #(
        .MAX_LIMBS (MAX_LIMBS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_cfg_wr     (w_cfg_wr),
        .i_limb_count (r_limb_count),
        .i_status     (w_status),
        .o_busy       (busy),
        .o_cmd        (w_cmd),
        .o_wr_idx     (w_wr_idx),
        .o_rd_i       (w_rd_i),
        .o_rd_j       (w_rd_j)
    );

    mpsm_datapath #(
        .MAX_LIMBS (MAX_LIMBS),
        .LIMB_BITS (LIMB_BITS),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_wr_idx       (w_wr_idx),
        .i_rd_i         (w_rd_i),
        .i_rd_j         (w_rd_j),
        .i_operands     (i_operands),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // top limb sits at 2n-1, always odd
    a_last_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last_limb |-> o_result.limb_position[0])
        else $error("top product limb at even position");

    // nothing follows the top limb of a product
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last_limb |=> !o_result_valid)
        else $error("result beat after top limb");

    // lower limbs only come out while the product is in flight
    a_busy_during: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.last_limb |-> busy)
        else $error("result beat while idle");

endmodule

// ===== dv/mpsm_checker.sv =====
// ----------------------------------------------------------------------------
// mpsm_checker
// Watches the operand, result and config channels of the product-scanning
// multiplier, predicts every product limb and compares result beats in order.
// ----------------------------------------------------------------------------
module mpsm_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  mpsm_pkg::t_operands  i_operands,
    input  logic                 i_result_valid,
    input  mpsm_pkg::t_result    i_result,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [2:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic                 i_pready,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_products
);
    timeunit 1ns;
    timeprecision 1ps;
    import mpsm_pkg::*;

    localparam int unsigned LIMB_MAX = 16;

    logic [63:0] u_limbs [LIMB_MAX];
    logic [63:0] v_limbs [LIMB_MAX];
    int unsigned pairs_held;
    logic [4:0]  limb_count_q;
    t_result     product_fifo [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_products   = 0;
        pairs_held   = 0;
        limb_count_q = 5'd1;
    end

    task automatic log_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic int unsigned active_limbs();
        if (limb_count_q == 5'd0) return 1;
        if (limb_count_q > LIMB_MAX) return LIMB_MAX;
        return 32'(limb_count_q);
    endfunction

    // Store one pair; on the completing pair scan all 2n columns.
    task automatic take_pair(input logic [63:0] u, input logic [63:0] v);
        int unsigned n;
        int unsigned lo_i;
        int unsigned hi_i;
        logic [191:0] acc;
        logic [127:0] prod;
        t_result limb;
        n = active_limbs();
        if (pairs_held >= n) pairs_held = 0;
        u_limbs[pairs_held] = u;
        v_limbs[pairs_held] = v;
        pairs_held++;
        if (pairs_held < n) return;
        acc = '0;
        for (int unsigned col = 0; col < 2 * n; col++) begin
            lo_i = (col >= n) ? col - n + 1 : 0;
            hi_i = (col < n) ? col : n - 1;
            if (col + 1 < 2 * n) begin
                for (int unsigned i = lo_i; i <= hi_i; i++) begin
                    prod = {64'b0, u_limbs[i]} * {64'b0, v_limbs[col - i]};
                    acc  = acc + {64'b0, prod};
                end
            end
            limb.product_limb  = acc[63:0];
            limb.limb_position = POS_W'(col);
            limb.last_limb     = (col + 1 == 2 * n);
            product_fifo.push_back(limb);
            acc = acc >> 64;
        end
        pairs_held = 0;
        o_products++;
    endtask

    always @(posedge i_clk) begin
        t_result exp_limb;
        if (!i_rst_n) begin
            pairs_held   = 0;
            limb_count_q = 5'd1;
            product_fifo.delete();
        end else begin
            if (i_result_valid) begin
                if (product_fifo.size() == 0) begin
                    log_mismatch($sformatf("unexpected result beat pos %0d limb %h",
                                           i_result.limb_position, i_result.product_limb));
                end else begin
                    exp_limb = product_fifo.pop_front();
                    o_checked++;
                    if (i_result.product_limb !== exp_limb.product_limb)
                        log_mismatch($sformatf("product_limb pos %0d: got %h want %h",
                                               exp_limb.limb_position,
                                               i_result.product_limb,
                                               exp_limb.product_limb));
                    if (i_result.limb_position !== exp_limb.limb_position)
                        log_mismatch($sformatf("limb_position: got %0d want %0d",
                                               i_result.limb_position,
                                               exp_limb.limb_position));
                    if (i_result.last_limb !== exp_limb.last_limb)
                        log_mismatch($sformatf("last_limb pos %0d: got %b want %b",
                                               exp_limb.limb_position,
                                               i_result.last_limb, exp_limb.last_limb));
                end
            end
            // limb_count write drops any partial load; other addresses ignored
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == REG_LIMB_COUNT) begin
                limb_count_q = i_pwdata[4:0];
                pairs_held   = 0;
            end
            if (i_start && !i_busy)
                take_pair(i_operands.u_limb, i_operands.v_limb);
        end
        o_pending = product_fifo.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the product-scanning multiplier core: directed and random
// limb-pair streams over many limb counts, checked beat by beat by mpsm_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mpsm_pkg::*;

    localparam int          RANDOM_PAIRS = 80;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [2:0]  ADDR_LIMB_COUNT = {REG_LIMB_COUNT, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED   = 3'd4;   // index 1: no register
    localparam logic [63:0] ALL_ONES = '1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_operands   i_operands = '0;
    logic        o_result_valid;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending, checked, products;
    int pairs_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    always #5 i_clk = ~i_clk;

    multiword_product_scanning_multiplier_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operands     (i_operands),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    mpsm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_operands     (i_operands),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_products     (products)
    );

    // Watchdog: covers 16-limb products with worst gaps many times over.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d limbs still expected",
                     cycle_count, pending);
            $display("multiword_product_scanning_multiplier_core verification failed");
            $finish;
        end
    end

    // Limb values biased toward the carry-heavy corners.
    function automatic logic [63:0] pick_limb();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return 64'd1 << $urandom_range(0, 63);
            3:       return ALL_ONES - $urandom_range(0, 3);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic int eff_limbs(input logic [4:0] cnt);
        if (cnt == 5'd0) return 1;
        if (cnt > 5'd16) return 16;
        return int'(cnt);
    endfunction

    // Gap with start low; the next beat raises start on a later falling edge.
    task automatic hold_off(input int cycles);
        if (cycles == 0) return;
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Present one pair and wait for the beat. start stays high afterwards so
    // back-to-back beats never drop it; the burst pacing lowers it.
    task automatic load_pair(input logic [63:0] u, input logic [63:0] v);
        @(negedge i_clk);
        start      <= 1'b1;
        i_operands <= '{u_limb: u, v_limb: v};
        do @(posedge i_clk); while (busy);
        pairs_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold_off($urandom_range(1, 6));
            // occasional long burst with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 30)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Quiet point for register writes: no limbs owed, core idle, then a margin
    // in case the last beat was a loading beat still in flight.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Limb count write with junk above the 5-bit field.
    task automatic set_limbs(input logic [4:0] cnt);
        settle();
        apb_write(ADDR_LIMB_COUNT, ($urandom() & ~32'h1f) | 32'(cnt));
    endtask

    initial begin
        logic [4:0] cnt;
        int n;
        int runs;
        int partial;
        int goal;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        // reset value is one limb: single 64x64 products at the corners
        load_pair(ALL_ONES, ALL_ONES);
        load_pair('0, '0);
        // zero count reads as one limb
        set_limbs(5'd0);
        load_pair(ALL_ONES, 64'd1);
        // two limbs, all ones: maximal column carries
        set_limbs(5'd2);
        load_pair(ALL_ONES, ALL_ONES);
        load_pair(ALL_ONES, ALL_ONES);
        // rewrite mid-load: the first pair is dropped, the next one is limb 0
        set_limbs(5'd4);
        load_pair(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        set_limbs(5'd3);
        load_pair(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        // write to an unmapped address must keep the partial load
        settle();
        apb_write(ADDR_UNMAPPED, $urandom());
        load_pair(ALL_ONES, 64'h8000_0000_0000_0000);
        load_pair(64'h0123_4567_89ab_cdef, ALL_ONES);
        // count above the store size saturates to 16 limbs
        set_limbs(5'd31);
        for (int i = 0; i < 16; i++) load_pair(ALL_ONES, ALL_ONES);

        // ---- random phases ----
        goal = pairs_sent + RANDOM_PAIRS;
        while (pairs_sent < goal) begin
            case ($urandom_range(0, 19))
                0, 1:    cnt = 5'($urandom_range(16, 31));
                2:       cnt = 5'd0;
                3, 4, 5: cnt = 5'($urandom_range(5, 15));
                default: cnt = 5'($urandom_range(1, 4));
            endcase
            n = eff_limbs(cnt);
            set_limbs(cnt);
            if ($urandom_range(0, 5) == 0) begin
                settle();
                apb_write(ADDR_UNMAPPED, $urandom());
            end
            runs = (n >= 8) ? 1 : $urandom_range(1, 4);
            repeat (runs) begin
                // now and then an aborted load, dropped by a rewrite
                if (n > 1 && $urandom_range(0, 7) == 0) begin
                    partial = $urandom_range(1, n - 1);
                    repeat (partial) load_pair(pick_limb(), pick_limb());
                    set_limbs(cnt);
                end
                repeat (n) load_pair(pick_limb(), pick_limb());
            end
        end

        // ---- drain ----
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d limb pairs into %0d products, %0d result beats checked",
                 pairs_sent, products, checked);
        $display("limb counts from zero to saturated, mid-load rewrites, unmapped writes");
        if (fail_count == 0 && pending == 0) begin
            $display("multiword_product_scanning_multiplier_core verification clean");
        end else begin
            $display("multiword_product_scanning_multiplier_core verification failed");
        end
        $finish;
    end

endmodule
